/* rtl/core/pevr_pkg.sv */
// ----------------------------------------------------------------------------
// pevr_pkg: shared types and constants
// Payload structs, channel codes and register indexes for the per-position
// event rate block.
// ----------------------------------------------------------------------------
package pevr_pkg;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned LEN_W      = 21;
   localparam int unsigned POS_W      = 20;
   localparam int unsigned RATE_W     = 17;
   localparam int unsigned SE_W       = 16;
   localparam int unsigned CSR_ADDR_W = 3;

   // fractional bits of the rate quotient and bits of the error quotient
   localparam int unsigned RATE_BITS  = 16;
   localparam int unsigned QUO_BITS   = 32;
   localparam int unsigned ROOT_BITS  = 16;

   localparam logic [RATE_W-1:0] RATE_ONE        = 17'h10000;
   localparam logic [SE_W-1:0]   SE_MAX          = 16'hFFFF;
   localparam logic [DATA_W-1:0] MIN_DEPTH_RESET = 32'd256;

   typedef enum logic [1:0] {
      CH_MISMATCH    = 2'd0,
      CH_INSERTION   = 2'd1,
      CH_DELETION    = 2'd2,
      CH_TERMINATION = 2'd3
   } channel_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_CHANNEL    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_DEPTH  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MASK_5P    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MASK_3P    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_REF_LENGTH = 3'd4;

   typedef struct packed {
      logic [DATA_W-1:0] events;
      logic [DATA_W-1:0] coverage;
      logic [DATA_W-1:0] read_ends;
   } req_payload_type;

   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic              reported;
      logic [RATE_W-1:0] rate;
      logic [SE_W-1:0]   std_error;
      logic              last;
   } rsp_payload_type;

endpackage

/* rtl/core/position_event_rate_with_error.sv */
// ----------------------------------------------------------------------------
// position_event_rate_with_error: per-position event rate and standard error
// Tests per-position event counts against the channel's depth and reports
// the Q1.16 rate and its binomial standard error, one position per item.
// ----------------------------------------------------------------------------
// One item is taken at a time. An item that is not reported or whose rate
// saturates at one skips the divider; one whose error saturates skips the
// error divide and the square root. One shared restoring divider gives one
// quotient bit per cycle (16 rate bits, then 32 bits of rate*(1-rate)/depth),
// and a digit-by-digit square root gives one root bit per cycle (16). Setup,
// multiply, range check and the output load each take a state of their own.
// The next item is taken in the cycle after its result is loaded. A deletion
// item at the first position gives no result and frees the input after
// setup. The deletion channel's closing item gives its second result from a
// state of its own. A finished result sits in the output register, so the
// next item is taken while it waits; a result that finds the output register
// still stalled holds the input until it moves in.
module position_event_rate_with_error #(
   parameter int unsigned MAX_POSITIONS = 1048576
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  pevr_pkg::req_payload_type           req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output pevr_pkg::rsp_payload_type           rsp_data,
   input  logic                                csr_we,
   input  logic [pevr_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [pevr_pkg::DATA_W-1:0]         csr_wdata
);
   import pevr_pkg::*;

   localparam int unsigned LEN_MAX = 2**LEN_W - 1;
   localparam int unsigned LEN_CAP = (MAX_POSITIONS < LEN_MAX) ? MAX_POSITIONS : LEN_MAX;
   localparam logic [LEN_W-1:0] LEN_CAP_V = LEN_W'(LEN_CAP);
   localparam int unsigned CNT_W = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_RDIV,
      ST_MUL,
      ST_SPREP,
      ST_SDIV,
      ST_SQRT,
      ST_DONE,
      ST_SECOND
   } state_type;

   state_type         state_ff, state_in;

   // configuration
   channel_type       channel_ff, channel_in;
   logic [DATA_W-1:0] min_depth_ff, min_depth_in;
   logic [LEN_W-1:0]  mask_5p_ff, mask_5p_in;
   logic [LEN_W-1:0]  mask_3p_ff, mask_3p_in;
   logic [LEN_W-1:0]  ref_len_ff, ref_len_in;

   // run state
   logic [LEN_W-1:0]  pos_cnt_ff, pos_cnt_in;
   logic [DATA_W-1:0] held_ff, held_in;

   // latched item
   logic [DATA_W-1:0] ev_ff, ev_in;
   logic [DATA_W-1:0] cov_ff, cov_in;
   logic [DATA_W-1:0] ends_ff, ends_in;

   // current result
   logic [LEN_W-1:0]  jpos_ff, jpos_in;
   logic [DATA_W-1:0] jdepth_ff, jdepth_in;
   logic              jlast_ff, jlast_in;
   logic              jrep_ff, jrep_in;
   logic              second_ff, second_in;
   logic [LEN_W-1:0]  pos2_ff, pos2_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic [SE_W-1:0]   se_ff, se_in;

   // shared divider / square root datapath
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dvd_ff, dvd_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [33:0]       prod_ff, prod_in;
   logic [17:0]       sq_rem_ff, sq_rem_in;
   logic [SE_W-1:0]   sq_root_ff, sq_root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   logic              req_acc, out_free;
   logic [LEN_W-1:0]  len_c;
   logic              final_c;
   logic [DATA_W-1:0] decide_c;
   logic              job_valid, job_second, job_last, job_rep;
   logic [LEN_W-1:0]  job_pos;
   logic [DATA_W-1:0] job_ev, job_depth;
   logic [32:0]       div_sh, div_diff;
   logic              div_ge;
   logic [19:0]       sq_sh, sq_trial;
   logic              sq_ge;
   logic [RATE_W-1:0] r_c, rc_c;
   logic              sat_c;

   // a position at or past the length counts as masked
   function automatic logic is_masked(input logic [LEN_W-1:0] p,
                                      input logic [LEN_W-1:0] n,
                                      input logic [LEN_W-1:0] m5,
                                      input logic [LEN_W-1:0] m3);
      logic [LEN_W-1:0] left;
      left = n - p;
      return (p >= n) || (p < m5) || (left <= m3);
   endfunction

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign len_c    = (ref_len_ff == '0) ? LEN_W'(1) :
                     (ref_len_ff > LEN_CAP_V) ? LEN_CAP_V : ref_len_ff;
   assign final_c  = ({1'b0, pos_cnt_ff} + (LEN_W+1)'(1)) >= {1'b0, len_c};
   assign decide_c = (cov_ff > ends_ff) ? (cov_ff - ends_ff) : '0;

   // pick the result that this item produces
   always_comb begin
      job_valid  = 1'b1;
      job_second = 1'b0;
      job_pos    = pos_cnt_ff;
      job_ev     = ev_ff;
      job_depth  = cov_ff;
      job_last   = final_c;
      unique case (channel_ff)
         CH_INSERTION: begin
            job_depth = decide_c;
         end
         CH_DELETION: begin
            job_valid  = (pos_cnt_ff != '0);
            job_second = final_c;
            job_pos    = pos_cnt_ff - LEN_W'(1);
            job_ev     = held_ff;
            job_depth  = decide_c;
            job_last   = 1'b0;
         end
         CH_MISMATCH, CH_TERMINATION: begin
            job_depth = cov_ff;
         end
      endcase
      job_rep = (job_depth != '0) && (job_depth >= min_depth_ff) &&
                !is_masked(job_pos, len_c, mask_5p_ff, mask_3p_ff);
   end

   assign div_sh   = {rem_ff, dvd_ff[DATA_W-1]};
   assign div_ge   = div_sh >= {1'b0, jdepth_ff};
   assign div_diff = div_sh - {1'b0, jdepth_ff};
   assign sq_sh    = {sq_rem_ff, dvd_ff[DATA_W-1 -: 2]};
   assign sq_trial = {2'b00, sq_root_ff, 2'b01};
   assign sq_ge    = sq_sh >= sq_trial;
   assign r_c      = {1'b0, quo_ff[RATE_BITS-1:0]};
   assign rc_c     = RATE_ONE - r_c;
   // error quotient reaches 2^32 (root saturates) when prod/2^24 >= depth
   assign sat_c    = {22'b0, prod_ff[33:24]} >= jdepth_ff;

   always_comb begin
      state_in     = state_ff;
      channel_in   = channel_ff;
      min_depth_in = min_depth_ff;
      mask_5p_in   = mask_5p_ff;
      mask_3p_in   = mask_3p_ff;
      ref_len_in   = ref_len_ff;
      pos_cnt_in   = pos_cnt_ff;
      held_in      = held_ff;
      ev_in        = ev_ff;
      cov_in       = cov_ff;
      ends_in      = ends_ff;
      jpos_in      = jpos_ff;
      jdepth_in    = jdepth_ff;
      jlast_in     = jlast_ff;
      jrep_in      = jrep_ff;
      second_in    = second_ff;
      pos2_in      = pos2_ff;
      rate_in      = rate_ff;
      se_in        = se_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      prod_in      = prod_ff;
      sq_rem_in    = sq_rem_ff;
      sq_root_in   = sq_root_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_we) begin
         unique case (csr_addr)
            CSR_CHANNEL:    channel_in   = channel_type'(csr_wdata[1:0]);
            CSR_MIN_DEPTH:  min_depth_in = csr_wdata;
            CSR_MASK_5P:    mask_5p_in   = csr_wdata[LEN_W-1:0];
            CSR_MASK_3P:    mask_3p_in   = csr_wdata[LEN_W-1:0];
            CSR_REF_LENGTH: ref_len_in   = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               ev_in    = req_data.events;
               cov_in   = req_data.coverage;
               ends_in  = req_data.read_ends;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            pos_cnt_in = final_c ? '0 : pos_cnt_ff + LEN_W'(1);
            held_in    = ev_ff;
            jpos_in    = job_pos;
            jdepth_in  = job_depth;
            jlast_in   = job_last;
            jrep_in    = job_rep;
            second_in  = job_second;
            pos2_in    = pos_cnt_ff;
            rate_in    = '0;
            se_in      = '0;
            rem_in     = job_ev;
            dvd_in     = '0;
            quo_in     = '0;
            cnt_in     = CNT_W'(RATE_BITS);
            if (!job_valid) begin
               state_in = job_second ? ST_SECOND : ST_IDLE;
            end else if (!job_rep) begin
               state_in = ST_DONE;
            end else if (job_ev >= job_depth) begin
               // rate saturates at one, error is zero
               rate_in  = RATE_ONE;
               state_in = ST_DONE;
            end else begin
               state_in = ST_RDIV;
            end
         end
         ST_RDIV, ST_SDIV: begin
            rem_in = div_ge ? div_diff[DATA_W-1:0] : div_sh[DATA_W-1:0];
            dvd_in = {dvd_ff[DATA_W-2:0], 1'b0};
            quo_in = {quo_ff[DATA_W-2:0], div_ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               if (state_ff == ST_RDIV) begin
                  state_in = ST_MUL;
               end else begin
                  dvd_in     = {quo_ff[DATA_W-2:0], div_ge};
                  sq_rem_in  = '0;
                  sq_root_in = '0;
                  cnt_in     = CNT_W'(ROOT_BITS);
                  state_in   = ST_SQRT;
               end
            end
         end
         ST_MUL: begin
            rate_in  = r_c;
            prod_in  = {17'b0, r_c} * {17'b0, rc_c};
            state_in = ST_SPREP;
         end
         ST_SPREP: begin
            if (sat_c) begin
               se_in    = SE_MAX;
               state_in = ST_DONE;
            end else begin
               rem_in   = {22'b0, prod_ff[33:24]};
               dvd_in   = {prod_ff[23:0], 8'b0};
               quo_in   = '0;
               cnt_in   = CNT_W'(QUO_BITS);
               state_in = ST_SDIV;
            end
         end
         ST_SQRT: begin
            sq_rem_in  = sq_ge ? 18'(sq_sh - sq_trial) : sq_sh[17:0];
            sq_root_in = {sq_root_ff[SE_W-2:0], sq_ge};
            dvd_in     = {dvd_ff[DATA_W-3:0], 2'b00};
            cnt_in     = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               se_in    = {sq_root_ff[SE_W-2:0], sq_ge};
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.position    = jpos_ff[POS_W-1:0];
               rsp_in.reported    = jrep_ff;
               rsp_in.rate        = rate_ff;
               rsp_in.std_error   = se_ff;
               rsp_in.last        = jlast_ff;
               state_in           = second_ff ? ST_SECOND : ST_IDLE;
            end
         end
         ST_SECOND: begin
            // closing deletion position: depth zero, never reported
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.position    = pos2_ff[POS_W-1:0];
               rsp_in.reported    = 1'b0;
               rsp_in.rate        = '0;
               rsp_in.std_error   = '0;
               rsp_in.last        = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         channel_ff   <= CH_MISMATCH;
         min_depth_ff <= MIN_DEPTH_RESET;
         mask_5p_ff   <= '0;
         mask_3p_ff   <= '0;
         ref_len_ff   <= LEN_W'(1);
         pos_cnt_ff   <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         second_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         channel_ff   <= channel_in;
         min_depth_ff <= min_depth_in;
         mask_5p_ff   <= mask_5p_in;
         mask_3p_ff   <= mask_3p_in;
         ref_len_ff   <= ref_len_in;
         pos_cnt_ff   <= pos_cnt_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         second_ff    <= second_in;
      end
      ev_ff      <= ev_in;
      cov_ff     <= cov_in;
      ends_ff    <= ends_in;
      jpos_ff    <= jpos_in;
      jdepth_ff  <= jdepth_in;
      jlast_ff   <= jlast_in;
      jrep_ff    <= jrep_in;
      pos2_ff    <= pos2_in;
      rate_ff    <= rate_in;
      se_ff      <= se_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      quo_ff     <= quo_in;
      prod_ff    <= prod_in;
      sq_rem_ff  <= sq_rem_in;
      sq_root_ff <= sq_root_in;
      rsp_ff     <= rsp_in;
   end

   a_unreported_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.reported |-> rsp_ff.rate == '0 && rsp_ff.std_error == '0)
      else $error("unreported item carries a nonzero rate or error");

   a_rate_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.rate <= RATE_ONE)
      else $error("rate above one");

   a_second_wraps: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SECOND |-> pos_cnt_ff == '0)
      else $error("closing result pending but position count did not wrap");

   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == ST_PREP)
      else $error("accepted item not taken into setup");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for position_event_rate_with_error
// Feeds reference positions through the valid/stall input channel and checks
// every result item against a bit-accurate rate and standard error predictor.
// A short directed table (reset state, field extremes, all four channels,
// masking, deletion lag and mid-run register changes) comes first. Random
// register settings with mostly complete reference runs follow. The input
// idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb;
   import pevr_pkg::*;

   localparam int unsigned MAX_POS      = 1048576;
   localparam int unsigned RANDOM_ITEMS = 1600;
   localparam int unsigned IDLE_WAIT    = 100;   // covers the longest reported path

   typedef struct {
      bit              is_cfg;
      channel_type     chan;
      logic [31:0]     md;
      logic [20:0]     m5;
      logic [20:0]     m3;
      logic [20:0]     len;
      req_payload_type item;
      bit              typed;
      rsp_payload_type want;
   } step_row_type;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_data;
   logic            csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [DATA_W-1:0]     csr_wdata;

   // predictor copy of registers and run state
   channel_type     cfg_channel   = CH_MISMATCH;
   logic [31:0]     cfg_min_depth = MIN_DEPTH_RESET;
   logic [20:0]     cfg_mask_5p   = '0;
   logic [20:0]     cfg_mask_3p   = '0;
   logic [20:0]     cfg_ref_len   = 21'd1;
   logic [20:0]     next_pos      = '0;
   logic [31:0]     held_ev       = '0;

   rsp_payload_type step_out [2];
   rsp_payload_type expected_rates [$];
   rsp_payload_type oldest_rate;
   step_row_type    directed_rows [$];

   bit              calm_sender;
   int unsigned     mismatches    = 0;
   int unsigned     items_sent    = 0;
   int unsigned     results_seen  = 0;
   int unsigned     reported_seen = 0;
   int unsigned     settings_done = 0;

   position_event_rate_with_error u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      int b;
      root = '0;
      for (b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   function automatic rsp_payload_type rate_result(logic [20:0] pos, logic [31:0] ev,
                                                   logic [31:0] depth, logic is_last,
                                                   logic [31:0] len);
      rsp_payload_type r;
      logic [31:0] p;
      logic [63:0] quot;
      logic [63:0] spread;
      logic [63:0] root;
      bit masked;
      p = 32'(pos);
      masked = (p >= len) || (p < 32'(cfg_mask_5p)) || ((len - p) <= 32'(cfg_mask_3p));
      r = '0;
      r.position = pos[19:0];
      r.last     = is_last;
      if (depth != 0 && depth >= cfg_min_depth && !masked) begin
         quot = ({32'd0, ev} << 16) / {32'd0, depth};
         if (quot > 64'(RATE_ONE)) quot = 64'(RATE_ONE);
         spread = (quot * (64'd65536 - quot) * 64'd256) / {32'd0, depth};
         root = int_sqrt(spread);
         if (root > 64'(SE_MAX)) root = 64'(SE_MAX);
         r.reported  = 1'b1;
         r.rate      = quot[RATE_W-1:0];
         r.std_error = root[SE_W-1:0];
      end
      return r;
   endfunction

   // advances the run state by one item; results land in step_out
   function automatic int predict_rates(req_payload_type item);
      logic [31:0] len;
      logic [31:0] p;
      logic [31:0] decide;
      bit fin;
      int n;
      len = 32'(cfg_ref_len);
      if (len > MAX_POS) len = MAX_POS;
      if (len == 0) len = 1;
      p   = 32'(next_pos);
      fin = (p + 1 >= len);
      decide = (item.coverage > item.read_ends) ? item.coverage - item.read_ends : '0;
      n = 0;
      case (cfg_channel)
         CH_INSERTION: begin
            step_out[n] = rate_result(next_pos, item.events, decide, fin, len);
            n++;
         end
         CH_DELETION: begin
            // depth of the previous position comes from this item
            if (p > 0) begin
               step_out[n] = rate_result(next_pos - 21'd1, held_ev, decide, 1'b0, len);
               n++;
            end
            if (fin) begin
               step_out[n] = rate_result(next_pos, item.events, '0, 1'b1, len);
               n++;
            end
         end
         default: begin
            step_out[n] = rate_result(next_pos, item.events, item.coverage, fin, len);
            n++;
         end
      endcase
      held_ev  = item.events;
      next_pos = fin ? '0 : next_pos + 21'd1;
      return n;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want,
                                  logic [19:0] pos);
      mismatches++;
      $display("mismatch %0d: %s at position %0d: got %0h, want %0h",
               mismatches, what, pos, got, want);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rates.size() == 0) begin
            report_mismatch("unexpected result item", 32'(rsp_data), '0, rsp_data.position);
         end else begin
            oldest_rate = expected_rates.pop_front();
            results_seen++;
            if (oldest_rate.reported) reported_seen++;
            if (rsp_data.position !== oldest_rate.position)
               report_mismatch("position", 32'(rsp_data.position),
                               32'(oldest_rate.position), oldest_rate.position);
            if (rsp_data.reported !== oldest_rate.reported)
               report_mismatch("reported", 32'(rsp_data.reported),
                               32'(oldest_rate.reported), oldest_rate.position);
            if (rsp_data.rate !== oldest_rate.rate)
               report_mismatch("rate", 32'(rsp_data.rate),
                               32'(oldest_rate.rate), oldest_rate.position);
            if (rsp_data.std_error !== oldest_rate.std_error)
               report_mismatch("std_error", 32'(rsp_data.std_error),
                               32'(oldest_rate.std_error), oldest_rate.position);
            if (rsp_data.last !== oldest_rate.last)
               report_mismatch("last", 32'(rsp_data.last),
                               32'(oldest_rate.last), oldest_rate.position);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 16);
      return $urandom_range(30, 100);
   endfunction

   function automatic logic [31:0] corner_value();
      case ($urandom_range(0, 4))
         0:       return 32'd0;
         1:       return 32'd1;
         2:       return 32'd255;
         3:       return 32'd256;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic req_payload_type random_item();
      req_payload_type it;
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         // realistic pileup: events and ends within coverage, a few ends past it
         it.coverage  = $urandom_range(0, 20000);
         it.events    = $urandom_range(0, it.coverage);
         it.read_ends = ($urandom_range(0, 9) == 0) ? it.coverage + $urandom_range(0, 500)
                                                    : $urandom_range(0, it.coverage / 2);
      end else if (r < 80) begin
         it.coverage  = $urandom;
         it.events    = $urandom_range(0, it.coverage);
         it.read_ends = $urandom_range(0, it.coverage);
      end else if (r < 95) begin
         it.events    = $urandom;
         it.coverage  = $urandom;
         it.read_ends = $urandom;
      end else begin
         it.events    = corner_value();
         it.coverage  = corner_value();
         it.read_ends = corner_value();
      end
      return it;
   endfunction

   function automatic logic [20:0] pick_mask(int unsigned eff);
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return '0;
      if (r < 80) return 21'($urandom_range(0, 3));
      if (r < 90) return 21'($urandom_range(0, eff));
      if (r < 95) return 21'd1048576;
      return 21'($urandom);
   endfunction

   function automatic step_row_type cfg_row(channel_type chan, logic [31:0] md,
                                            logic [20:0] m5, logic [20:0] m3,
                                            logic [20:0] len);
      step_row_type s;
      s = '{chan: CH_MISMATCH, default: '0};
      s.is_cfg = 1'b1;
      s.chan = chan;
      s.md = md;
      s.m5 = m5;
      s.m3 = m3;
      s.len = len;
      return s;
   endfunction

   function automatic step_row_type item_row(logic [31:0] ev, logic [31:0] cov,
                                             logic [31:0] ends);
      step_row_type s;
      s = '{chan: CH_MISMATCH, default: '0};
      s.item.events = ev;
      s.item.coverage = cov;
      s.item.read_ends = ends;
      return s;
   endfunction

   // reset settings: every item is position 0 and closes its one-position run
   function automatic step_row_type typed_row(logic [31:0] ev, logic [31:0] cov,
                                              logic [31:0] ends, logic rep,
                                              logic [16:0] rate, logic [15:0] se);
      step_row_type s;
      s = item_row(ev, cov, ends);
      s.typed = 1'b1;
      s.want.position = '0;
      s.want.reported = rep;
      s.want.rate = rate;
      s.want.std_error = se;
      s.want.last = 1'b1;
      return s;
   endfunction

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(channel_type chan, logic [31:0] md, logic [20:0] m5,
                               logic [20:0] m3, logic [20:0] len);
      write_reg(CSR_CHANNEL, 32'(chan));
      write_reg(CSR_MIN_DEPTH, md);
      write_reg(CSR_MASK_5P, 32'(m5));
      write_reg(CSR_MASK_3P, 32'(m3));
      write_reg(CSR_REF_LENGTH, 32'(len));
      csr_we <= 1'b0;
      cfg_channel   = chan;
      cfg_min_depth = md;
      cfg_mask_5p   = m5;
      cfg_mask_3p   = m3;
      cfg_ref_len   = len;
      settings_done++;
   endtask

   // valid stays high on return so a back-to-back item follows without a dip
   task automatic send_item(req_payload_type item, bit typed, rsp_payload_type want);
      int gap;
      int n;
      int i;
      gap = calm_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n = predict_rates(item);
      if (typed) begin
         expected_rates.push_back(want);
      end else begin
         for (i = 0; i < n; i++) expected_rates.push_back(step_out[i]);
      end
      items_sent++;
   endtask

   // items with no result can still be in flight, hence the extra wait
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rates.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   initial begin : rsp_stall_gen
      int hold;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 6);
         repeat (hold) @(posedge clock);
         rsp_stall <= 1'b1;
         repeat (pick_gap() + 1) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   initial begin : main_seq
      step_row_type s;
      channel_type ch;
      logic [31:0] md;
      logic [20:0] len;
      int unsigned eff;
      int unsigned phase_items;
      int unsigned random_sent;
      int r;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_addr    = '0;
      csr_wdata   = '0;
      calm_sender = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings, typed-in results
      directed_rows.push_back(typed_row(32'd0, 32'd0, 32'd0, 1'b0, 17'd0, 16'd0));
      directed_rows.push_back(typed_row(32'd256, 32'd256, 32'd0, 1'b1, RATE_ONE, 16'd0));
      directed_rows.push_back(typed_row(32'hFFFF_FFFF, 32'd256, 32'd0, 1'b1, RATE_ONE, 16'd0));
      directed_rows.push_back(typed_row(32'd128, 32'd256, 32'd0, 1'b1, 17'd32768, 16'd32768));
      directed_rows.push_back(typed_row(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 17'd0,
                                        16'd0));
      directed_rows.push_back(typed_row(32'd0, 32'd255, 32'd0, 1'b0, 17'd0, 16'd0));
      directed_rows.push_back(typed_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1, RATE_ONE,
                                        16'd0));
      // termination, no depth floor: tiny depth saturates the error, zero depth is not reported
      directed_rows.push_back(cfg_row(CH_TERMINATION, 32'd0, 21'd0, 21'd0, 21'd4));
      directed_rows.push_back(item_row(32'd1, 32'd3, 32'd0));
      directed_rows.push_back(item_row(32'd1, 32'd1, 32'd0));
      directed_rows.push_back(item_row(32'd100, 32'd0, 32'd0));
      directed_rows.push_back(item_row(32'd5, 32'd1000, 32'd7));
      // insertion: 5' mask, ends past coverage floor at zero
      directed_rows.push_back(cfg_row(CH_INSERTION, 32'd256, 21'd1, 21'd0, 21'd4));
      directed_rows.push_back(item_row(32'd10, 32'd1000, 32'd0));
      directed_rows.push_back(item_row(32'd10, 32'd100, 32'd200));
      directed_rows.push_back(item_row(32'd50, 32'd1000, 32'd200));
      directed_rows.push_back(item_row(32'd10, 32'd1000, 32'd999));
      // deletion: one-item lag, closing item gives two results
      directed_rows.push_back(cfg_row(CH_DELETION, 32'd0, 21'd0, 21'd0, 21'd3));
      directed_rows.push_back(item_row(32'd7, 32'd500, 32'd0));
      directed_rows.push_back(item_row(32'd20, 32'd400, 32'd100));
      directed_rows.push_back(item_row(32'd30, 32'd100, 32'd100));
      directed_rows.push_back(item_row(32'd40, 32'd800, 32'd0));
      directed_rows.push_back(item_row(32'd60, 32'd900, 32'd300));
      // length cut below the current position: next item closes the run, all masked
      directed_rows.push_back(cfg_row(CH_DELETION, 32'd0, 21'd0, 21'd0, 21'd1));
      directed_rows.push_back(item_row(32'd5, 32'd700, 32'd0));
      // length zero acts as one; both masks set to 2^20
      directed_rows.push_back(cfg_row(CH_MISMATCH, 32'hFFFF_FFFF, 21'd1048576, 21'd1048576,
                                      21'd0));
      directed_rows.push_back(item_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0));
      // oversized length clips to the maximum; only full depth meets the floor
      directed_rows.push_back(cfg_row(CH_MISMATCH, 32'hFFFF_FFFF, 21'd0, 21'd0,
                                      21'h1F_FFFF));
      directed_rows.push_back(item_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0));
      directed_rows.push_back(item_row(32'd1, 32'hFFFF_FFFE, 32'd0));
      // switch to deletion mid-run, then away again, dropping the pending one
      directed_rows.push_back(cfg_row(CH_DELETION, 32'd256, 21'd0, 21'd0, 21'd8));
      directed_rows.push_back(item_row(32'd3, 32'd300, 32'd0));
      directed_rows.push_back(item_row(32'd4, 32'd400, 32'd0));
      directed_rows.push_back(cfg_row(CH_MISMATCH, 32'd256, 21'd0, 21'd0, 21'd8));
      directed_rows.push_back(item_row(32'd9, 32'd300, 32'd0));

      foreach (directed_rows[i]) begin
         s = directed_rows[i];
         if (s.is_cfg) begin
            wait_idle();
            program_regs(s.chan, s.md, s.m5, s.m3, s.len);
         end else begin
            send_item(s.item, s.typed, s.want);
         end
      end

      // random settings; mostly whole runs so every position and the closing item occur
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         wait_idle();
         ch = channel_type'($urandom_range(0, 3));
         r = $urandom_range(0, 99);
         if (r < 30)      md = 32'd256;
         else if (r < 50) md = 32'd0;
         else if (r < 70) md = $urandom_range(0, 4096);
         else if (r < 80) md = $urandom_range(0, 1 << 17);
         else if (r < 95) md = $urandom;
         else             md = 32'hFFFF_FFFF;
         r = $urandom_range(0, 99);
         if (r < 70)      len = 21'($urandom_range(1, 16));
         else if (r < 85) len = 21'($urandom_range(17, 120));
         else if (r < 90) len = 21'd0;
         else if (r < 95) len = 21'd1048576;
         else             len = 21'($urandom);
         eff = (len == 0) ? 1 : ((32'(len) > MAX_POS) ? MAX_POS : 32'(len));
         program_regs(ch, md, pick_mask(eff), pick_mask(eff), len);
         if (eff <= 40)
            phase_items = eff * $urandom_range(1, 3)
                        + (($urandom_range(0, 2) == 0) ? $urandom_range(0, eff) : 0);
         else
            phase_items = $urandom_range(5, 100);
         calm_sender = ($urandom_range(0, 3) == 0);
         repeat (phase_items) send_item(random_item(), 1'b0, '0);
         random_sent += phase_items;
      end

      wait_idle();
      $display("covered %0d items over %0d register settings: all channels, masks, length",
               items_sent, settings_done);
      $display("extremes and mid-run changes; %0d results checked, %0d with a rate",
               results_seen, reported_seen);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // several times the slowest legal run
   initial begin : watchdog
      #30_000_000;
      $display("timeout with %0d results outstanding", expected_rates.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
